// ----- rtl/core/rcast_pkg.sv -----
// Shared constants, codes and control types of the grid ray caster.
package rcast_pkg;

  localparam int GRID_SIZE   = 64;
  localparam int SCREEN_ROWS = 480;
  localparam int MAX_STEPS   = 128;

  localparam int EYE_W      = 22;
  localparam int DIR_W      = 19;
  localparam int CAM_W      = 18;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int GXY_W      = 6;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W  = 3;

  localparam int FRAC_W    = 16;
  localparam int FRAC1_W   = FRAC_W + 1;
  localparam int EYE_INT_W = EYE_W - FRAC_W;
  localparam int PROD_W    = DIR_W + CAM_W;
  localparam int RD_W      = ((PROD_W - FRAC_W > DIR_W) ? PROD_W - FRAC_W : DIR_W) + 1;
  localparam int DELTA_W   = 32;
  localparam int DVD_W     = DELTA_W + 1;
  localparam int SIDE0_W   = FRAC1_W + DELTA_W - FRAC_W;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int SD_W      = SIDE0_W + STEP_W;
  localparam int DVS_W     = SD_W;

  localparam int GRID_IDX_W = $clog2(GRID_SIZE);
  localparam int CELL_W     = ((GRID_IDX_W > EYE_INT_W) ? GRID_IDX_W : EYE_INT_W) + 2;
  localparam int MAP_DEPTH  = GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W     = $clog2(MAP_DEPTH);

  localparam int H_MAX     = 2 * SCREEN_ROWS;
  localparam int H_W       = $clog2(H_MAX + 1);
  localparam int ES_W      = H_W + 1;
  localparam int HALF_ROWS = SCREEN_ROWS / 2;

  localparam logic [DVD_W-1:0] RECIP_NUM  = DVD_W'(64'd1 << (2 * FRAC_W));
  localparam logic [DVD_W-1:0] HEIGHT_NUM = DVD_W'(64'(SCREEN_ROWS) << FRAC_W);
  localparam logic [FRAC1_W-1:0] FRAC_ONE = FRAC1_W'(64'd1 << FRAC_W);

  localparam logic signed [CELL_W-1:0] CELL_ONE  = CELL_W'(1);
  localparam logic signed [CELL_W-1:0] CELL_ZERO = '0;
  localparam logic signed [CELL_W-1:0] CELL_GRID = CELL_W'(GRID_SIZE);

  localparam logic REQ_MAP_WRITE = 1'b0;
  localparam logic REQ_CAST      = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_X   = 3'd0,
    CFG_EYE_Y   = 3'd1,
    CFG_VIEW_X  = 3'd2,
    CFG_VIEW_Y  = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_CLEAR, OP_MUL, OP_SUM, OP_DX_GO, OP_DX_WAIT, OP_DY_GO, OP_DY_WAIT,
    OP_SIDE, OP_STEP, OP_TEST, OP_PERP, OP_H_GO, OP_H_WAIT, OP_ROWS, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic step_limit;
    logic hit;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/rcast_req_if.sv -----
// Request channel: map writes and ray casts.
interface rcast_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [rcast_pkg::GXY_W-1:0] grid_x;
  logic [rcast_pkg::GXY_W-1:0] grid_y;
  logic is_wall;
  logic [rcast_pkg::COL_W-1:0] column;
  logic signed [rcast_pkg::CAM_W-1:0] cam_offset;

  modport source(output valid, req_type, grid_x, grid_y, is_wall, column, cam_offset,
                 input ready);
  modport sink(input valid, req_type, grid_x, grid_y, is_wall, column, cam_offset,
               output ready);
endinterface

// ----- rtl/core/rcast_res_if.sv -----
// Result channel: one wall slice per ray cast.
interface rcast_res_if;
  logic valid;
  logic ready;
  logic [rcast_pkg::COL_W-1:0] out_column;
  logic [rcast_pkg::ROW_W-1:0] draw_start;
  logic [rcast_pkg::ROW_W-1:0] draw_end;
  logic wall_side;
  logic hit_found;

  modport source(output valid, out_column, draw_start, draw_end, wall_side, hit_found,
                 input ready);
  modport sink(input valid, out_column, draw_start, draw_end, wall_side, hit_found,
               output ready);
endinterface

// ----- rtl/core/rcast_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module rcast_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rcast_pkg::DVD_W-1:0] dividend,
  input  logic [rcast_pkg::DVS_W-1:0] divisor,
  output logic                        done,
  output logic [rcast_pkg::DVD_W-1:0] quotient
);
  import rcast_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVD_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             fits;

  // A zero divisor always fits, which yields an all-ones quotient.
  assign trial    = {rem, acc[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : DVS_W'(trial);
        acc <= {acc[DVD_W-2:0], fits};
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/rcast_dp.sv -----
// Datapath: configuration, wall map, ray setup, grid walk and slice rows.
module rcast_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rcast_pkg::dp_cmd_t                  cmd,
  output rcast_pkg::dp_status_t               st,
  input  logic                                accept,
  input  logic                                req_type,
  input  logic [rcast_pkg::GXY_W-1:0]         grid_x,
  input  logic [rcast_pkg::GXY_W-1:0]         grid_y,
  input  logic                                is_wall,
  input  logic [rcast_pkg::COL_W-1:0]         column,
  input  logic signed [rcast_pkg::CAM_W-1:0]  cam_offset,
  input  logic                                cfg_we,
  input  logic [rcast_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcast_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                res_ready,
  output logic                                res_valid,
  output logic [rcast_pkg::COL_W-1:0]         out_column,
  output logic [rcast_pkg::ROW_W-1:0]         draw_start,
  output logic [rcast_pkg::ROW_W-1:0]         draw_end,
  output logic                                wall_side,
  output logic                                hit_found
);
  import rcast_pkg::*;

  logic [EYE_W-1:0]        eye_x, eye_y;
  logic signed [DIR_W-1:0] view_x, view_y, plane_x, plane_y;

  logic [COL_W-1:0]         col_q;
  logic signed [CAM_W-1:0]  cam_q;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [RD_W-1:0]   rd_x, rd_y;
  logic [RD_W-1:0]          abs_x, abs_y;
  logic [DELTA_W-1:0]       dx, dy;
  logic [FRAC1_W-1:0]       frac_x, frac_y;
  logic [FRAC1_W+DELTA_W-1:0] side_px, side_py;
  logic [SD_W-1:0]          sdx, sdy, perp;
  logic signed [CELL_W-1:0] mx, my, nmx, nmy;
  logic [STEP_W-1:0]        n;
  logic                     step_x, oob_n, oob_q, side, hit;
  logic [H_W-1:0]           height, half;
  logic [ES_W-1:0]          end_sum;
  logic [ROW_W-1:0]         row_start, row_end;

  logic [ADDR_W-1:0] clr_cnt, map_waddr, map_raddr;
  logic              map_we, map_wdata, map_q, wr_in_grid;
  logic              map_mem [MAP_DEPTH];

  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x   <= '0;
      eye_y   <= '0;
      view_x  <= DIR_W'(65536);
      view_y  <= '0;
      plane_x <= '0;
      plane_y <= DIR_W'(43254);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EYE_X:   eye_x   <= cfg_data[EYE_W-1:0];
        CFG_EYE_Y:   eye_y   <= cfg_data[EYE_W-1:0];
        CFG_VIEW_X:  view_x  <= cfg_data[DIR_W-1:0];
        CFG_VIEW_Y:  view_y  <= cfg_data[DIR_W-1:0];
        CFG_PLANE_X: plane_x <= cfg_data[DIR_W-1:0];
        CFG_PLANE_Y: plane_y <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Wall map: cleared by a sweep after reset, written by map-write transactions.
  assign wr_in_grid = int'(grid_x) < GRID_SIZE && int'(grid_y) < GRID_SIZE;
  assign map_we     = (cmd.op == OP_CLEAR) ||
                      (accept && req_type == REQ_MAP_WRITE && wr_in_grid);
  assign map_waddr  = (cmd.op == OP_CLEAR) ? clr_cnt
                      : ADDR_W'(int'(grid_x) * GRID_SIZE + int'(grid_y));
  assign map_wdata  = (cmd.op == OP_CLEAR) ? 1'b0 : is_wall;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.op == OP_STEP) map_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  // Ray setup helpers.
  assign abs_x  = rd_x[RD_W-1] ? RD_W'(-rd_x) : RD_W'(rd_x);
  assign abs_y  = rd_y[RD_W-1] ? RD_W'(-rd_y) : RD_W'(rd_y);
  assign frac_x = rd_x[RD_W-1] ? {1'b0, eye_x[FRAC_W-1:0]} : FRAC_ONE - {1'b0, eye_x[FRAC_W-1:0]};
  assign frac_y = rd_y[RD_W-1] ? {1'b0, eye_y[FRAC_W-1:0]} : FRAC_ONE - {1'b0, eye_y[FRAC_W-1:0]};
  assign side_px = frac_x * dx;
  assign side_py = frac_y * dy;

  assign div_dvd = (cmd.op == OP_H_GO) ? HEIGHT_NUM : RECIP_NUM;
  assign div_dvs = (cmd.op == OP_H_GO)  ? perp
                 : (cmd.op == OP_DY_GO) ? SD_W'(abs_y) : SD_W'(abs_x);

  rcast_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // One DDA step: advance along the axis whose boundary is nearer.
  always_comb begin
    step_x = sdx < sdy;
    nmx = mx;
    nmy = my;
    if (step_x) nmx = rd_x[RD_W-1] ? mx - CELL_ONE : mx + CELL_ONE;
    else        nmy = rd_y[RD_W-1] ? my - CELL_ONE : my + CELL_ONE;
    oob_n = nmx < CELL_ZERO || nmx >= CELL_GRID || nmy < CELL_ZERO || nmy >= CELL_GRID;
    map_raddr = ADDR_W'(int'(nmx[GRID_IDX_W-1:0]) * GRID_SIZE + int'(nmy[GRID_IDX_W-1:0]));
  end

  assign half    = height >> 1;
  assign end_sum = ES_W'(HALF_ROWS) + ES_W'(half);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_IDLE: begin
        if (accept) begin
          col_q <= column;
          cam_q <= cam_offset;
        end
      end
      OP_MUL: begin
        prod_x <= plane_x * cam_q;
        prod_y <= plane_y * cam_q;
      end
      OP_SUM: begin
        rd_x <= RD_W'(view_x) + RD_W'(prod_x >>> FRAC_W);
        rd_y <= RD_W'(view_y) + RD_W'(prod_y >>> FRAC_W);
      end
      OP_DX_WAIT: if (div_done) dx <= div_q[DVD_W-1] ? '1 : div_q[DELTA_W-1:0];
      OP_DY_WAIT: if (div_done) dy <= div_q[DVD_W-1] ? '1 : div_q[DELTA_W-1:0];
      OP_SIDE: begin
        sdx  <= SD_W'(side_px >> FRAC_W);
        sdy  <= SD_W'(side_py >> FRAC_W);
        mx   <= CELL_W'(eye_x[EYE_W-1:FRAC_W]);
        my   <= CELL_W'(eye_y[EYE_W-1:FRAC_W]);
        n    <= '0;
        side <= 1'b0;
        hit  <= 1'b0;
      end
      OP_STEP: begin
        if (!st.step_limit) begin
          if (step_x) begin
            sdx  <= sdx + SD_W'(dx);
            side <= 1'b0;
          end else begin
            sdy  <= sdy + SD_W'(dy);
            side <= 1'b1;
          end
          mx    <= nmx;
          my    <= nmy;
          n     <= n + STEP_W'(1);
          oob_q <= oob_n;
        end
      end
      OP_TEST: hit <= oob_q | map_q;
      OP_PERP: perp <= side ? sdy - SD_W'(dy) : sdx - SD_W'(dx);
      OP_H_WAIT: begin
        if (div_done) height <= (div_q > DVD_W'(H_MAX)) ? H_W'(H_MAX) : H_W'(div_q);
      end
      OP_ROWS: begin
        if (hit) begin
          row_start <= (half > H_W'(HALF_ROWS)) ? '0 : ROW_W'(H_W'(HALF_ROWS) - half);
          row_end   <= (end_sum >= ES_W'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1)
                                                       : ROW_W'(end_sum);
        end else begin
          row_start <= '0;
          row_end   <= '0;
        end
      end
      default: ;
    endcase
  end

  // Output register: a finished slice waits here until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.op == OP_OUT && st.out_free) begin
        res_valid  <= 1'b1;
        out_column <= col_q;
        draw_start <= row_start;
        draw_end   <= row_end;
        wall_side  <= hit & side;
        hit_found  <= hit;
      end
    end
  end

  assign st.clear_last = clr_cnt == ADDR_W'(MAP_DEPTH - 1);
  assign st.div_done   = div_done;
  assign st.step_limit = n == STEP_W'(MAX_STEPS);
  assign st.hit        = oob_q | map_q;
  assign st.out_free   = !res_valid || res_ready;
endmodule

// ----- rtl/core/rcast_ctrl.sv -----
// Controller: sequences map clearing, ray setup, grid walk and result hand-off.
module rcast_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  cast_req,
  input  rcast_pkg::dp_status_t st,
  output rcast_pkg::dp_cmd_t    cmd,
  output logic                  in_ready
);
  import rcast_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MUL, S_SUM, S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT,
    S_SIDE, S_STEP, S_TEST, S_PERP, S_H_GO, S_H_WAIT, S_ROWS, S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR:   if (st.clear_last) state <= S_IDLE;
        S_IDLE:    if (accept && cast_req) state <= S_MUL;
        S_MUL:     state <= S_SUM;
        S_SUM:     state <= S_DX_GO;
        S_DX_GO:   state <= S_DX_WAIT;
        S_DX_WAIT: if (st.div_done) state <= S_DY_GO;
        S_DY_GO:   state <= S_DY_WAIT;
        S_DY_WAIT: if (st.div_done) state <= S_SIDE;
        S_SIDE:    state <= S_STEP;
        S_STEP:    state <= st.step_limit ? S_ROWS : S_TEST;
        S_TEST:    state <= st.hit ? S_PERP : S_STEP;
        S_PERP:    state <= S_H_GO;
        S_H_GO:    state <= S_H_WAIT;
        S_H_WAIT:  if (st.div_done) state <= S_ROWS;
        S_ROWS:    state <= S_OUT;
        S_OUT:     if (st.out_free) state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:    cmd.op = OP_IDLE;
      S_CLEAR:   cmd.op = OP_CLEAR;
      S_MUL:     cmd.op = OP_MUL;
      S_SUM:     cmd.op = OP_SUM;
      S_DX_GO:   cmd.op = OP_DX_GO;
      S_DX_WAIT: cmd.op = OP_DX_WAIT;
      S_DY_GO:   cmd.op = OP_DY_GO;
      S_DY_WAIT: cmd.op = OP_DY_WAIT;
      S_SIDE:    cmd.op = OP_SIDE;
      S_STEP:    cmd.op = OP_STEP;
      S_TEST:    cmd.op = OP_TEST;
      S_PERP:    cmd.op = OP_PERP;
      S_H_GO:    cmd.op = OP_H_GO;
      S_H_WAIT:  cmd.op = OP_H_WAIT;
      S_ROWS:    cmd.op = OP_ROWS;
      S_OUT:     cmd.op = OP_OUT;
    endcase
    cmd.div_start = state == S_DX_GO || state == S_DY_GO || state == S_H_GO;
  end

  assign in_ready = state == S_IDLE;
endmodule

// ----- rtl/core/grid_dda_raycaster.sv -----
// Grid ray caster top level: DDA walk over a wall bitmap, one slice per ray.
// Requests arrive on the req channel; a transaction with req_type 0 writes one
// map cell (ignored outside the grid) and yields no result, req_type 1 casts the
// ray for one screen column and yields exactly one transaction on res.
// The viewer position, view direction and camera plane are set through the
// cfg_we / cfg_index / cfg_data write port; the user is to write it only while
// no ray is in flight, and the block itself does not enforce it. Two reciprocals
// and the height division run on one shared radix-2 divider, and each walk step
// passes a step state, which reads the registered map memory, and a test state;
// a ray walks at most MAX_STEPS cells.
// One item is worked on at a time; req.ready is high only while idle.
// After reset the map memory is swept to empty before the first request is
// taken; configuration writes are taken during that sweep. The result sits in
// an output register; when the sink stalls, it waits there while new requests
// are still taken. A following ray then halts in its final state, with
// req.ready low, until the register frees.
module grid_dda_raycaster (
  input  logic                             clk,
  input  logic                             rst,
  rcast_req_if.sink                        req,
  rcast_res_if.source                      res,
  input  logic                             cfg_we,
  input  logic [rcast_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcast_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rcast_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  logic       in_ready;
  logic       accept;

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  rcast_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cast_req (req.req_type == REQ_CAST),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  rcast_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .accept     (accept),
    .req_type   (req.req_type),
    .grid_x     (req.grid_x),
    .grid_y     (req.grid_y),
    .is_wall    (req.is_wall),
    .column     (req.column),
    .cam_offset (req.cam_offset),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_ready  (res.ready),
    .res_valid  (res.valid),
    .out_column (res.out_column),
    .draw_start (res.draw_start),
    .draw_end   (res.draw_end),
    .wall_side  (res.wall_side),
    .hit_found  (res.hit_found)
  );

  // A map write never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_MAP_WRITE) |=> !$rose(res.valid))
    else $error("result raised after a map write");

  // A wall slice starts no lower than it ends (it always spans the screen center).
  a_slice_order: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.hit_found) |-> (res.draw_start <= res.draw_end))
    else $error("slice start below slice end");

  // A walk ended by the step limit reports an empty slice.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.hit_found) |->
      (res.draw_start == '0 && res.draw_end == '0 && !res.wall_side))
    else $error("missed ray carries slice data");

  // The map sweep after reset keeps the request channel closed.
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CLEAR) |-> !req.ready)
    else $error("request accepted during map clear");
endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the grid ray caster: map writes, ray casts and view settings.
`timescale 1ns / 100ps

module tb_top;
  import rcast_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam longint unsigned DELTA_SAT = 64'hFFFF_FFFF;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_first;
    logic [ROW_W-1:0] row_last;
    logic             side;
    logic             hit;
  } slice_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rcast_req_if req ();
  rcast_res_if res ();

  grid_dda_raycaster i_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req.sink),
    .res      (res.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block state.
  logic [EYE_W-1:0]        eye_x_q, eye_y_q;
  logic signed [DIR_W-1:0] view_x_q, view_y_q, plane_x_q, plane_y_q;
  bit                      walls [MAP_DEPTH];

  slice_t slices_due [$];
  int     failures = 0;
  bit     src_idle_on = 1'b1;
  bit     snk_idle_on = 1'b1;
  bit     long_hold_req = 1'b0;
  int     hold_cnt = 0;

  function automatic longint unsigned inv_len(longint signed d);
    longint unsigned a, q;
    if (d == 0) return DELTA_SAT;
    a = (d < 0) ? -d : d;
    q = (64'd1 << 32) / a;
    return (q > DELTA_SAT) ? DELTA_SAT : q;
  endfunction

  function automatic bit blocked(longint signed x, longint signed y);
    if (x < 0 || y < 0 || x >= GRID_SIZE || y >= GRID_SIZE) return 1'b1;
    return walls[x * GRID_SIZE + y];
  endfunction

  function automatic void setup_axis(input logic [EYE_W-1:0] eye, input longint signed dir,
                                     input longint unsigned delta,
                                     output longint signed start_cell,
                                     output longint signed dstep,
                                     output longint unsigned side_dist);
    longint unsigned frac;
    start_cell = eye >> FRAC_W;
    if (dir < 0) begin
      dstep = -1;
      frac  = eye[FRAC_W-1:0];
    end else begin
      dstep = 1;
      frac  = 65536 - eye[FRAC_W-1:0];
    end
    side_dist = (frac * delta) >> FRAC_W;
  endfunction

  function automatic slice_t trace_ray(logic [COL_W-1:0] col, logic signed [CAM_W-1:0] cam);
    longint signed   c, rdx, rdy, mx, my, sx, sy, hlf, first, last;
    longint unsigned dx, dy, sdx, sdy, perp, height;
    bit              side, hit;
    slice_t          r;
    c    = cam;
    rdx  = longint'(view_x_q) + ((longint'(plane_x_q) * c) >>> FRAC_W);
    rdy  = longint'(view_y_q) + ((longint'(plane_y_q) * c) >>> FRAC_W);
    dx   = inv_len(rdx);
    dy   = inv_len(rdy);
    side = 1'b0;
    hit  = 1'b0;
    setup_axis(eye_x_q, rdx, dx, mx, sx, sdx);
    setup_axis(eye_y_q, rdy, dy, my, sy, sdy);
    for (int n = 0; n < MAX_STEPS; n++) begin
      if (sdx < sdy) begin
        sdx += dx;
        mx += sx;
        side = 1'b0;
      end else begin
        sdy += dy;
        my += sy;
        side = 1'b1;
      end
      if (blocked(mx, my)) begin
        hit = 1'b1;
        break;
      end
    end
    r = '0;
    r.column = col;
    if (!hit) return r;
    perp = side ? sdy - dy : sdx - dx;
    if (perp == 0) begin
      height = 2 * SCREEN_ROWS;
    end else begin
      height = (longint'(SCREEN_ROWS) << FRAC_W) / perp;
      if (height > 2 * SCREEN_ROWS) height = 2 * SCREEN_ROWS;
    end
    hlf   = height / 2;
    first = SCREEN_ROWS / 2 - hlf;
    if (first < 0) first = 0;
    last = SCREEN_ROWS / 2 + hlf;
    if (last >= SCREEN_ROWS) last = SCREEN_ROWS - 1;
    r.row_first = first[ROW_W-1:0];
    r.row_last  = last[ROW_W-1:0];
    r.side      = side;
    r.hit       = 1'b1;
    return r;
  endfunction

  // Sender side. It is entered at a falling edge and leaves valid high.
  task automatic send_req(bit kind, logic [GXY_W-1:0] gx, logic [GXY_W-1:0] gy, bit wall,
                          logic [COL_W-1:0] col, logic signed [CAM_W-1:0] cam);
    while (src_idle_on && $urandom_range(99) < 25) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.grid_x     <= gx;
    req.grid_y     <= gy;
    req.is_wall    <= wall;
    req.column     <= col;
    req.cam_offset <= cam;
    do @(posedge clk); while (!req.ready);
    if (kind == REQ_CAST) slices_due.push_back(trace_ray(col, cam));
    else walls[gx * GRID_SIZE + gy] = wall;
    @(negedge clk);
  endtask

  task automatic put_wall(int x, int y, bit wall);
    send_req(REQ_MAP_WRITE, GXY_W'(x), GXY_W'(y), wall, COL_W'($urandom), CAM_W'($urandom));
  endtask

  task automatic cast(logic [COL_W-1:0] col, logic signed [CAM_W-1:0] cam);
    send_req(REQ_CAST, GXY_W'($urandom), GXY_W'($urandom), 1'($urandom), col, cam);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (slices_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_EYE_X:   eye_x_q   = data;
      CFG_EYE_Y:   eye_y_q   = data;
      CFG_VIEW_X:  view_x_q  = data[DIR_W-1:0];
      CFG_VIEW_Y:  view_y_q  = data[DIR_W-1:0];
      CFG_PLANE_X: plane_x_q = data[DIR_W-1:0];
      CFG_PLANE_Y: plane_y_q = data[DIR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(int ex, int ey, int vx, int vy, int px, int py);
    wait_idle();
    cfg_write(CFG_EYE_X, CFG_DATA_W'(ex));
    cfg_write(CFG_EYE_Y, CFG_DATA_W'(ey));
    cfg_write(CFG_VIEW_X, CFG_DATA_W'(vx));
    cfg_write(CFG_VIEW_Y, CFG_DATA_W'(vy));
    cfg_write(CFG_PLANE_X, CFG_DATA_W'(px));
    cfg_write(CFG_PLANE_Y, CFG_DATA_W'(py));
  endtask

  function automatic int rand_dir();
    if ($urandom_range(9) == 0) return 0;
    return $urandom_range(262144) - 131072;
  endfunction

  task automatic test_reset_view();
    cast(10'd0, -18'sd65536);
    cast(10'd320, 18'sd0);
    cast(10'd639, 18'sd65536);
    cast(10'd1023, 18'sh1FFFF);
    cast(10'd512, 18'sh20000);
  endtask

  task automatic test_zero_distance();
    // Eye on a cell boundary looking back at the wall behind it: distance zero.
    set_view(5 << 16, (10 << 16) + 32768, -65536, 0, 0, 0);
    put_wall(4, 10, 1'b1);
    put_wall(63, 63, 1'b1);
    put_wall(0, 0, 1'b0);
    cast(10'd1, 18'sd0);
    cast(10'd2, 18'sd1000);
  endtask

  task automatic test_extremes();
    set_view(0, 0, 131072, 131072, -131072, 131072);
    cast(10'd3, -18'sd65536);
    cast(10'd4, 18'sd65536);
    set_view(4194303, 4194303, -131072, -131072, 131072, -131072);
    cast(10'd5, 18'sd0);
    cast(10'd6, 18'sh20000);
    set_view(32 << 16, 32 << 16, 19'h3FFFF, 19'h40000, 0, 0);
    cast(10'd7, 18'sd0);
    set_view(1 << 16, 2 << 16, 0, 0, 0, 0);
    cast(10'd8, 18'sd0);
    // Writes to the spare indexes must leave the view unchanged.
    wait_idle();
    cfg_write(CFG_SPARE_A, 22'h3FFFFF);
    cfg_write(CFG_SPARE_B, 22'h155555);
    cast(10'd9, 18'sd12345);
    put_wall(1, 2, 1'b1);
    put_wall(1, 2, 1'b0);
  endtask

  task automatic test_random(int phases, int per_phase);
    int density;
    for (int p = 0; p < phases; p++) begin
      src_idle_on = (p != 3);
      snk_idle_on = (p != 3);
      wait_idle();
      cfg_write(CFG_EYE_X, CFG_DATA_W'($urandom));
      cfg_write(CFG_EYE_Y, CFG_DATA_W'($urandom));
      cfg_write(CFG_VIEW_X, CFG_DATA_W'(($urandom & 22'h3C0000) | (rand_dir() & 22'h7FFFF)));
      cfg_write(CFG_VIEW_Y, CFG_DATA_W'(rand_dir()));
      cfg_write(CFG_PLANE_X, CFG_DATA_W'(rand_dir()));
      cfg_write(CFG_PLANE_Y, CFG_DATA_W'(rand_dir()));
      density = $urandom_range(40);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(99) < 20)
          put_wall($urandom, $urandom, $urandom_range(99) < density);
        else if ($urandom_range(9) == 0)
          cast(COL_W'($urandom), CAM_W'($urandom));
        else
          cast(COL_W'($urandom_range(639)), CAM_W'($urandom_range(131072) - 65536));
      end
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_idle();
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      cast(COL_W'($urandom_range(639)), CAM_W'($urandom_range(131072) - 65536));
  endtask

  // Result side: ready changes at the falling edge.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_cnt = 1500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !(snk_idle_on && $urandom_range(99) < 25);
      end
    end
  end

  always @(posedge clk) begin
    slice_t got, want;
    if (!rst && res.valid && res.ready) begin
      got = '{res.out_column, res.draw_start, res.draw_end, res.wall_side, res.hit_found};
      if (slices_due.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, got);
        failures++;
      end else begin
        want = slices_due.pop_front();
        if (got.column !== want.column || got.row_first !== want.row_first ||
            got.row_last !== want.row_last || got.side !== want.side ||
            got.hit !== want.hit) begin
          $display("%0t: slice mismatch, expected %p, actual %p", $time, want, got);
          failures++;
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_MAP_WRITE;
    req.grid_x = '0;
    req.grid_y = '0;
    req.is_wall = 1'b0;
    req.column = '0;
    req.cam_offset = '0;
    eye_x_q = '0;
    eye_y_q = '0;
    view_x_q = 65536;
    view_y_q = 0;
    plane_x_q = 0;
    plane_y_q = 43254;
    foreach (walls[i]) walls[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_view();
    test_zero_distance();
    test_extremes();
    test_backpressure();
    test_random(10, 130);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/rcast_pkg.sv
rtl/core/rcast_req_if.sv
rtl/core/rcast_res_if.sv
rtl/core/rcast_div.sv
rtl/core/rcast_dp.sv
rtl/core/rcast_ctrl.sv
rtl/core/grid_dda_raycaster.sv
verif/tb_top.sv
